// File: hw/rtl/four_point_contour_smoother_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the four-point contour smoother.
// Shared property forms, clocked on the rising edge and held off in reset.
// ---------------------------------------------------------------------------
`ifndef FOUR_POINT_CONTOUR_SMOOTHER_TOP_DEFINES_SVH
`define FOUR_POINT_CONTOUR_SMOOTHER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPCS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/fpcs_pkg.sv
// ---------------------------------------------------------------------------
// fpcs_pkg
// Types and constants shared by the contour smoother modules.
// ---------------------------------------------------------------------------
package fpcs_pkg;

  localparam int SCALE_BITS = 16;
  localparam int RATIO_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_LIMIT_LOG = 62;
  localparam int CHAIN_DEPTH = 6;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd13107;

  // Register index, taken from address bit 2.
  localparam logic REG_BEND_SCALE = 1'b0;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_NEXT = 4'b0010,
    T_CALC = 4'b0100,
    T_SEND = 4'b1000
  } top_state_t;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SQ23X = 12'b000000000010,
    S_SQ23Y = 12'b000000000100,
    S_RT23  = 12'b000000001000,
    S_SQ14X = 12'b000000010000,
    S_SQ14Y = 12'b000000100000,
    S_RT14  = 12'b000001000000,
    S_DIV   = 12'b000010000000,
    S_GMUL  = 12'b000100000000,
    S_XMUL  = 12'b001000000000,
    S_YMUL  = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } sm_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } sm_ctrl_t;

endpackage

// File: hw/rtl/four_point_contour_smoother_top.sv
// ---------------------------------------------------------------------------
// four_point_contour_smoother_top
// Smooths a contour polyline by inserting one point between inner pairs.
// ---------------------------------------------------------------------------
// Usage. Vertices enter on the s_ stream, one beat per vertex, with s_tuser
// giving the contour kind (0 open, 1 closed) and s_tlast on the final vertex.
// Smoothed vertices leave on the m_ stream, m_tlast on the final one. The
// APB port holds bend_scale (Q0.16) at address 0; write it only while idle.
// One vertex is worked on at a time: s_tready is high only while the block
// has nothing in flight. A vertex yields zero to six output beats. A copied
// vertex passes through T_NEXT into the registered output beat. An inserted
// point goes through a shared bit-serial multiplier, square root and divider,
// sized by M = max(COORD_BITS+2, 32); the divide is skipped when the outer
// chord has zero length. The closing vertex of a closed contour needs up to
// three inserted points. That serial datapath sets the throughput.
// When the receiver holds m_tready low the output beat stays registered and
// the sequencer waits. Reset clears the window, the head vertices, the
// vertex count and the sequencer, and sets bend_scale to 0.2.
// ---------------------------------------------------------------------------
`include "four_point_contour_smoother_top_defines.svh"

module four_point_contour_smoother_top #(
  parameter int COORD_BITS = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Vertex input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,  // x_in, y_in, zero fill
  input  logic [0:0]  s_tuser,                         // mode
  input  logic        s_tlast,
  // Smoothed vertex output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,  // x_out, y_out, zero fill
  output logic        m_tlast
);

  localparam int C   = COORD_BITS;
  localparam int DBW = ((2*C+7)/8)*8;
  localparam int CD  = fpcs_pkg::CHAIN_DEPTH;

  // Configuration register.
  logic [fpcs_pkg::SCALE_BITS-1:0] scale;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == fpcs_pkg::REG_BEND_SCALE) ? 32'(scale) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= fpcs_pkg::SCALE_RESET;
    end else if (cfg_wr && paddr[2] == fpcs_pkg::REG_BEND_SCALE) begin
      scale <= pwdata[fpcs_pkg::SCALE_BITS-1:0];
    end
  end

  // Contour state: the last three vertices and the first three.
  logic [2:0][2*C-1:0] win;
  logic [2:0][2*C-1:0] head;
  logic [COUNT_BITS-1:0] count;

  // Per-vertex plan. The chain holds the points in emission order; an
  // inserted point always uses chain slots 0..3 and the copied vertex is
  // always slot 2, after which the chain shifts down by one.
  logic [CD-1:0][2*C-1:0] chain, chain_next;
  logic [2:0] n_out, n_out_next;
  logic [1:0] n_pairs, n_pairs_next;
  logic [2:0] j;
  logic       item_last;

  fpcs_pkg::top_state_t state;
  fpcs_pkg::sm_ctrl_t   sm_req, sm_rsp;
  logic [C-1:0] qx, qy;
  logic [C-1:0] ox, oy;

  logic accept;
  logic [2*C-1:0] pin;
  logic kge3;
  logic [1:0] ks;

  assign s_tready = (state == fpcs_pkg::T_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign pin      = s_tdata[2*C-1:0];
  assign kge3     = (count >= COUNT_BITS'(3));
  assign ks       = count[1:0];

  always_comb begin
    chain_next   = {head[2], head[1], pin, win[2], win[1], win[0]};
    n_out_next   = 3'd0;
    n_pairs_next = 2'd0;
    if (!s_tuser[0]) begin
      // Open contour.
      if (kge3) begin
        n_pairs_next = 2'd1;
        n_out_next   = s_tlast ? 3'd3 : 3'd2;
      end else if (ks == 2'd2) begin
        chain_next[2] = pin;
        n_out_next    = s_tlast ? 3'd1 : 3'd0;
      end else begin
        chain_next[2] = pin;
        n_out_next    = 3'd1;
      end
    end else if (s_tlast) begin
      // Closing vertex of a closed contour: wrap through the head vertices.
      if (kge3) begin
        chain_next[3] = head[0];
        n_pairs_next  = 2'd3;
        n_out_next    = 3'd6;
      end else begin
        case (ks)
          2'd0: begin
            chain_next[2] = pin;
            n_out_next    = 3'd1;
          end
          2'd1: begin
            chain_next[2] = head[0];
            chain_next[3] = pin;
            n_out_next    = 3'd2;
          end
          default: begin
            chain_next[2] = head[0];
            chain_next[3] = head[1];
            chain_next[4] = pin;
            n_out_next    = 3'd3;
          end
        endcase
      end
    end else begin
      if (kge3) begin
        n_pairs_next = 2'd1;
        n_out_next   = 3'd2;
      end else if (ks == 2'd2) begin
        chain_next[2] = head[1];
        n_out_next    = 3'd1;
      end
    end
  end

  logic want_smooth;
  assign want_smooth = !j[0] && (j < {n_pairs, 1'b0});
  assign sm_req.start = (state == fpcs_pkg::T_NEXT) && (j != n_out) && want_smooth;
  assign sm_req.done  = 1'b0;

  fpcs_smooth #(.C(C)) u_smooth (
    .clk(clk), .rst(rst), .ctrl_in(sm_req), .ctrl_out(sm_rsp),
    .pts({chain[3], chain[2], chain[1], chain[0]}), .scale(scale), .qx(qx), .qy(qy)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fpcs_pkg::T_IDLE;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      count    <= '0;
      win      <= '0;
      head     <= '0;
      j        <= '0;
      n_out    <= '0;
      n_pairs  <= '0;
    end else begin
      unique case (state)
        fpcs_pkg::T_IDLE: begin
          if (accept) begin
            n_out     <= n_out_next;
            n_pairs   <= n_pairs_next;
            j         <= '0;
            win       <= {pin, win[2], win[1]};
            if (!kge3) head[ks] <= pin;
            if (s_tlast) count <= '0;
            else if (count != '1) count <= count + 1'b1;
            state <= fpcs_pkg::T_NEXT;
          end
        end
        fpcs_pkg::T_NEXT: begin
          if (j == n_out) begin
            state <= fpcs_pkg::T_IDLE;
          end else if (want_smooth) begin
            state <= fpcs_pkg::T_CALC;
          end else begin
            j        <= j + 1'b1;
            m_tvalid <= 1'b1;
            m_tlast  <= item_last && (j + 1'b1 == n_out);
            state    <= fpcs_pkg::T_SEND;
          end
        end
        fpcs_pkg::T_CALC: begin
          if (sm_rsp.done) begin
            j        <= j + 1'b1;
            m_tvalid <= 1'b1;
            m_tlast  <= item_last && (j + 1'b1 == n_out);
            state    <= fpcs_pkg::T_SEND;
          end
        end
        fpcs_pkg::T_SEND: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= fpcs_pkg::T_NEXT;
          end
        end
        default: state <= fpcs_pkg::T_IDLE;
      endcase
    end
  end

  // Payload: chain, item flag and output coordinates.
  always_ff @(posedge clk) begin
    if (accept) begin
      chain     <= chain_next;
      item_last <= s_tlast;
    end else if (state == fpcs_pkg::T_NEXT && j != n_out && !want_smooth) begin
      ox <= chain[2][C-1:0];
      oy <= chain[2][2*C-1:C];
      for (int i = 0; i < CD - 1; i++) begin
        chain[i] <= chain[i+1];
      end
    end else if (state == fpcs_pkg::T_CALC && sm_rsp.done) begin
      ox <= qx;
      oy <= qy;
    end
  end

  assign m_tdata = DBW'({oy, ox});

  // The output beat is only presented while the sequencer is sending.
  `FPCS_ASSERT_SAME(a_valid_in_send, clk, rst, m_tvalid, state == fpcs_pkg::T_SEND, "beat outside send")
  // The step index never runs past the planned beat count.
  `FPCS_ASSERT_SAME(a_step_bound, clk, rst, 1'b1, j <= n_out, "step index past plan")
  // A started smoothing job always moves the sequencer into its calculation state.
  `FPCS_ASSERT_NEXT(a_start_calc, clk, rst, sm_req.start, state == fpcs_pkg::T_CALC, "start lost")
  // The final beat of a contour closes the plan of its vertex.
  `FPCS_ASSERT_SAME(a_last_final, clk, rst, m_tvalid && m_tlast, j == n_out && item_last, "bad last")

endmodule

// File: hw/rtl/fpcs_mul.sv
// ---------------------------------------------------------------------------
// fpcs_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module fpcs_mul #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] p
);

  localparam int CW = $clog2(W + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [2*W-1:0] sh_a;
  logic [W-1:0]   sh_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p    <= '0;
      sh_a <= {{W{1'b0}}, a};
      sh_b <= b;
    end else if (run) begin
      if (sh_b[0]) begin
        p <= p + sh_a;
      end
      sh_a <= {sh_a[2*W-2:0], 1'b0};
      sh_b <= {1'b0, sh_b[W-1:1]};
    end
  end

endmodule

// File: hw/rtl/fpcs_sqrt.sv
// ---------------------------------------------------------------------------
// fpcs_sqrt
// Restoring integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module fpcs_sqrt #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2*W-1:0] rad,
  output logic           done,
  output logic [W-1:0]   root
);

  localparam int CW = $clog2(W + 1);

  logic           run;
  logic [CW-1:0]  cnt;
  logic [2*W-1:0] sh;
  logic [W-1:0]   rem;
  logic [W+1:0]   rem_s;
  logic [W+1:0]   trial;
  logic           fits;

  assign rem_s = {rem, sh[2*W-1:2*W-2]};
  assign trial = {root, 2'b01};
  assign fits  = (rem_s >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= rad;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      sh <= {sh[2*W-3:0], 2'b00};
      if (fits) begin
        rem  <= W'(rem_s - trial);
        root <= {root[W-2:0], 1'b1};
      end else begin
        rem  <= W'(rem_s);
        root <= {root[W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hw/rtl/fpcs_div.sv
// ---------------------------------------------------------------------------
// fpcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fpcs_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [NW-1:0] sh;
  logic [DW-1:0] dv;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_s;
  logic          fits;

  assign rem_s = {rem, sh[NW-1]};
  assign fits  = (rem_s >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= num;
      dv  <= den;
      rem <= '0;
      quo <= '0;
    end else if (run) begin
      sh <= {sh[NW-2:0], 1'b0};
      if (fits) begin
        rem <= DW'(rem_s - {1'b0, dv});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= DW'(rem_s);
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hw/rtl/fpcs_smooth.sv
// ---------------------------------------------------------------------------
// fpcs_smooth
// Sequencer that computes one inserted point from a four-point window,
// sharing a serial multiplier, square root and divider.
// ---------------------------------------------------------------------------
module fpcs_smooth #(
  parameter int C = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fpcs_pkg::sm_ctrl_t    ctrl_in,
  output fpcs_pkg::sm_ctrl_t    ctrl_out,
  input  logic [3:0][2*C-1:0]   pts,
  input  logic [fpcs_pkg::SCALE_BITS-1:0] scale,
  output logic [C-1:0]          qx,
  output logic [C-1:0]          qy
);

  localparam int MW = (C + 2 > 32) ? C + 2 : 32;
  localparam int PW = 2 * MW;
  localparam int TW = PW + 2;
  localparam int RB = fpcs_pkg::RATIO_BITS;
  localparam int FB = fpcs_pkg::FRAC_BITS;
  localparam logic [PW-1:0] LIMIT = PW'(1) << fpcs_pkg::PROD_LIMIT_LOG;
  localparam logic signed [TW-1:0] HI = TW'((64'sd1 <<< (C - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] LO = -HI - TW'(1);

  fpcs_pkg::sm_state_t state;
  logic kick;
  logic [3:0][2*C-1:0] pt;
  logic [PW-1:0] sqa;
  logic [PW-1:0] rad;
  logic [MW-1:0] l23;
  logic [MW-1:0] l14;
  logic [RB-1:0] ratio;
  logic [RB-1:0] g;

  logic signed [C-1:0] x1, x2, x3, x4, y1, y2, y3, y4;
  assign x1 = pt[0][C-1:0];
  assign y1 = pt[0][2*C-1:C];
  assign x2 = pt[1][C-1:0];
  assign y2 = pt[1][2*C-1:C];
  assign x3 = pt[2][C-1:0];
  assign y3 = pt[2][2*C-1:C];
  assign x4 = pt[3][C-1:0];
  assign y4 = pt[3][2*C-1:C];

  // Segment deltas and their magnitudes.
  logic signed [C:0] dx23, dy23, dx14, dy14;
  logic [C:0] ux23, uy23, ux14, uy14;
  assign dx23 = (C+1)'(x2) - (C+1)'(x3);
  assign dy23 = (C+1)'(y2) - (C+1)'(y3);
  assign dx14 = (C+1)'(x1) - (C+1)'(x4);
  assign dy14 = (C+1)'(y1) - (C+1)'(y4);
  assign ux23 = dx23[C] ? (C+1)'(-dx23) : (C+1)'(dx23);
  assign uy23 = dy23[C] ? (C+1)'(-dy23) : (C+1)'(dy23);
  assign ux14 = dx14[C] ? (C+1)'(-dx14) : (C+1)'(dx14);
  assign uy14 = dy14[C] ? (C+1)'(-dy14) : (C+1)'(dy14);

  // Offset of mid23 against mid14, doubled, per axis.
  logic signed [C:0]   sx23, sy23;
  logic signed [C+1:0] ex, ey;
  logic [C+1:0] mx, my;
  assign sx23 = (C+1)'(x2) + (C+1)'(x3);
  assign sy23 = (C+1)'(y2) + (C+1)'(y3);
  assign ex = (C+2)'(sx23) - (C+2)'(x1) - (C+2)'(x4);
  assign ey = (C+2)'(sy23) - (C+2)'(y1) - (C+2)'(y4);
  assign mx = ex[C+1] ? (C+2)'(-ex) : (C+2)'(ex);
  assign my = ey[C+1] ? (C+2)'(-ey) : (C+2)'(ey);

  // Shared serial units.
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_p;
  logic mul_done, sqrt_done, div_done;
  logic [MW-1:0] sqrt_root;
  logic [MW+FB-1:0] div_q;
  logic mul_start, sqrt_start, div_start;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      fpcs_pkg::S_SQ23X: begin mul_a = MW'(ux23); mul_b = MW'(ux23); end
      fpcs_pkg::S_SQ23Y: begin mul_a = MW'(uy23); mul_b = MW'(uy23); end
      fpcs_pkg::S_SQ14X: begin mul_a = MW'(ux14); mul_b = MW'(ux14); end
      fpcs_pkg::S_SQ14Y: begin mul_a = MW'(uy14); mul_b = MW'(uy14); end
      fpcs_pkg::S_GMUL:  begin mul_a = MW'(ratio); mul_b = MW'(scale); end
      fpcs_pkg::S_XMUL:  begin mul_a = MW'(mx); mul_b = MW'(g); end
      fpcs_pkg::S_YMUL:  begin mul_a = MW'(my); mul_b = MW'(g); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_start = kick && (state == fpcs_pkg::S_SQ23X || state == fpcs_pkg::S_SQ23Y ||
                              state == fpcs_pkg::S_SQ14X || state == fpcs_pkg::S_SQ14Y ||
                              state == fpcs_pkg::S_GMUL  || state == fpcs_pkg::S_XMUL  ||
                              state == fpcs_pkg::S_YMUL);
  assign sqrt_start = kick && (state == fpcs_pkg::S_RT23 || state == fpcs_pkg::S_RT14);
  assign div_start  = kick && (state == fpcs_pkg::S_DIV);

  fpcs_mul #(.W(MW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  fpcs_sqrt #(.W(MW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .rad(rad),
    .done(sqrt_done), .root(sqrt_root)
  );

  fpcs_div #(.NW(MW + FB), .DW(MW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num({l23, FB'(0)}), .den(l14),
    .done(div_done), .quo(div_q)
  );

  // Final combine: t = s23*2^16 +/- |e|*g, rounded half up by 2^17, saturated.
  function automatic logic [C-1:0] axis_value(input logic signed [C:0] s23,
                                              input logic neg,
                                              input logic [PW-1:0] prod);
    logic signed [TW-1:0] tot;
    logic signed [TW-1:0] res;
    logic [C-1:0] v;
    tot = TW'(s23) <<< FB;
    if (neg) tot = tot - TW'(prod);
    else tot = tot + TW'(prod);
    tot = tot + (TW'(1) <<< FB);
    res = tot >>> (FB + 1);
    if (prod > LIMIT) v = neg ? C'(LO) : C'(HI);
    else if (res > HI) v = C'(HI);
    else if (res < LO) v = C'(LO);
    else v = C'(res);
    return v;
  endfunction

  logic [PW-1:0] gsum;
  assign gsum = mul_p + PW'(1 << (FB - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpcs_pkg::S_IDLE;
      kick  <= 1'b0;
    end else begin
      kick <= 1'b0;
      unique case (state)
        fpcs_pkg::S_IDLE:  if (ctrl_in.start) begin state <= fpcs_pkg::S_SQ23X; kick <= 1'b1; end
        fpcs_pkg::S_SQ23X: if (mul_done) begin state <= fpcs_pkg::S_SQ23Y; kick <= 1'b1; end
        fpcs_pkg::S_SQ23Y: if (mul_done) begin state <= fpcs_pkg::S_RT23; kick <= 1'b1; end
        fpcs_pkg::S_RT23:  if (sqrt_done) begin state <= fpcs_pkg::S_SQ14X; kick <= 1'b1; end
        fpcs_pkg::S_SQ14X: if (mul_done) begin state <= fpcs_pkg::S_SQ14Y; kick <= 1'b1; end
        fpcs_pkg::S_SQ14Y: if (mul_done) begin state <= fpcs_pkg::S_RT14; kick <= 1'b1; end
        fpcs_pkg::S_RT14: begin
          if (sqrt_done) begin
            state <= (sqrt_root == '0) ? fpcs_pkg::S_GMUL : fpcs_pkg::S_DIV;
            kick  <= 1'b1;
          end
        end
        fpcs_pkg::S_DIV:   if (div_done) begin state <= fpcs_pkg::S_GMUL; kick <= 1'b1; end
        fpcs_pkg::S_GMUL:  if (mul_done) begin state <= fpcs_pkg::S_XMUL; kick <= 1'b1; end
        fpcs_pkg::S_XMUL:  if (mul_done) begin state <= fpcs_pkg::S_YMUL; kick <= 1'b1; end
        fpcs_pkg::S_YMUL:  if (mul_done) state <= fpcs_pkg::S_DONE;
        fpcs_pkg::S_DONE:  state <= fpcs_pkg::S_IDLE;
        default: state <= fpcs_pkg::S_IDLE;
      endcase
    end
  end

  assign ctrl_out.start = 1'b0;
  assign ctrl_out.done  = (state == fpcs_pkg::S_DONE);

  always_ff @(posedge clk) begin
    if (state == fpcs_pkg::S_IDLE && ctrl_in.start) pt <= pts;
    if (mul_done && state == fpcs_pkg::S_SQ23X) sqa <= mul_p;
    if (mul_done && state == fpcs_pkg::S_SQ14X) sqa <= mul_p;
    if (mul_done && (state == fpcs_pkg::S_SQ23Y || state == fpcs_pkg::S_SQ14Y)) begin
      rad <= sqa + mul_p;
    end
    if (sqrt_done && state == fpcs_pkg::S_RT23) l23 <= sqrt_root;
    if (sqrt_done && state == fpcs_pkg::S_RT14) begin
      l14 <= sqrt_root;
      if (sqrt_root == '0) ratio <= '0;
    end
    if (div_done) begin
      ratio <= (|div_q[MW+FB-1:RB]) ? '1 : div_q[RB-1:0];
    end
    if (mul_done && state == fpcs_pkg::S_GMUL) g <= gsum[FB+RB-1:FB];
    if (mul_done && state == fpcs_pkg::S_XMUL) qx <= axis_value(sx23, ex[C+1], mul_p);
    if (mul_done && state == fpcs_pkg::S_YMUL) qy <= axis_value(sy23, ey[C+1], mul_p);
  end

endmodule
